>>> hdl/wsc_pkg.sv
package wsc_pkg;

  localparam int NUM_CH      = 5;
  localparam int WAVE_LEN    = 32;
  localparam int WAVE_DEPTH  = NUM_CH * WAVE_LEN;
  localparam int WAVE_AW     = $clog2(WAVE_DEPTH);
  localparam int CH_W        = $clog2(NUM_CH);
  localparam int POS_W       = $clog2(WAVE_LEN);

  localparam int DIVN_W      = 34;
  localparam int DIVD_W      = 22;
  localparam int DIV_CNT_W   = $clog2(DIVN_W + 1);

  localparam logic [7:0] ADDR_COMPAT_WAVE_END = 8'h80;
  localparam logic [7:0] ADDR_PLUS_WAVE_END   = 8'ha0;
  localparam logic [2:0] SEG_COMPAT_CTRL      = 3'b100;
  localparam logic [2:0] SEG_PLUS_CTRL        = 3'b101;
  localparam logic [2:0] SEG_COMPAT_WAVE4     = 3'b101;
  localparam logic [2:0] SEG_DEFORM           = 3'b110;
  localparam logic [1:0] SEG_WAVE3            = 2'd3;
  localparam logic [2:0] WAVE4_CH             = 3'd4;

  localparam logic [25:0] RST_CHIP_HZ = 26'd3579545;
  localparam logic [17:0] RST_RATE_HZ = 18'd44100;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_RENDER = 2'd2,
    CMD_SRESET = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    CFG_PLUS_MODE = 2'd0,
    CFG_CHIP_HZ   = 2'd1,
    CFG_RATE_HZ   = 2'd2
  } cfg_index_t;

  typedef enum logic {
    KIND_READ   = 1'b0,
    KIND_SAMPLE = 1'b1
  } result_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DUP,
    S_RD,
    S_DIV1,
    S_CH,
    S_SUB,
    S_MRD,
    S_MACC,
    S_AVG,
    S_DIV2,
    S_FIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic dup_wr;
    logic div1_start;
    logic div2_start;
    logic div1_take;
    logic ch_start;
    logic sub_step;
    logic ch_next;
    logic mix_rd;
    logic mix_acc;
    logic tick_inc;
    logic load_read;
    logic load_sample;
  } dp_cmd_t;

  typedef struct packed {
    cmd_code_t kind;
    logic      dup;
    logic      rate_zero;
    logic      div_busy;
    logic      q_zero;
    logic      short_period;
    logic      cnt_ge;
    logic      last_ch;
    logic      ticks_zero;
    logic      last_tick;
    logic      out_busy;
  } dp_stat_t;

  function automatic logic [11:0] narrow_period(input logic [11:0] raw, input logic [7:0] dfm);
    logic [11:0] p;
    p = raw;
    if (dfm[1]) begin
      p = {4'd0, raw[7:0]};
    end else if (dfm[0]) begin
      p = {8'd0, raw[11:8]};
    end
    return p;
  endfunction

endpackage

>>> hdl/wsc_ram.sv
module wsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 160
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> hdl/wsc_div.sv
module wsc_div import wsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVN_W-1:0] dividend,
  input  logic [DIVD_W-1:0] divisor,
  output logic              busy,
  output logic [DIVN_W-1:0] quotient,
  output logic [DIVD_W-1:0] remainder
);

  logic [DIVN_W-1:0]    qr;
  logic [DIVD_W-1:0]    rem;
  logic [DIVD_W-1:0]    dvs;
  logic [DIV_CNT_W-1:0] count;
  logic [DIVD_W:0]      rem_sh;
  logic [DIVD_W:0]      diff;
  logic                 ge;

  assign rem_sh = {rem, qr[DIVN_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= DIV_CNT_W'(DIVN_W);
      qr    <= dividend;
      rem   <= '0;
      dvs   <= divisor;
    end else if (busy) begin
      qr    <= {qr[DIVN_W-2:0], ge};
      rem   <= ge ? diff[DIVD_W-1:0] : rem_sh[DIVD_W-1:0];
      count <= count - 1'b1;
      if (count == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient  = qr;
  assign remainder = rem;

endmodule

>>> hdl/wsc_dp.sv
module wsc_dp import wsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [15:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [25:0] cfg_data,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  output logic [0:0]  m_tuser
);

  logic        plus_mode;
  logic [25:0] chip_hz;
  logic [17:0] rate_hz;

  logic [3:0]  vol   [NUM_CH];
  logic [11:0] raw   [NUM_CH];
  logic [11:0] act   [NUM_CH];
  logic [12:0] phase [NUM_CH];
  logic [POS_W-1:0] pos [NUM_CH];
  logic [NUM_CH-1:0] enable;
  logic [7:0]  deform;
  logic [17:0] clk_rem;

  logic [WAVE_DEPTH-1:0] wvalid;
  logic        wvalid_q;
  logic [7:0]  ram_q;
  logic        ram_we;
  logic [WAVE_AW-1:0] ram_addr;
  logic [7:0]  ram_wdata;

  logic [CH_W-1:0]   ch;
  logic [13:0]       cnt;
  logic [13:0]       per;
  logic [DIVD_W-1:0] ticks;
  logic [DIVD_W-1:0] tick_cnt;
  logic signed [DIVN_W-1:0] sum;
  logic [7:0]  lat_addr;
  logic [7:0]  lat_data;
  logic [WAVE_AW-1:0] lat_rd_idx;
  logic        rd_mapped;

  logic        out_valid;
  logic        out_kind;
  logic [7:0]  out_rdata;
  logic [15:0] out_sample;

  logic [7:0]  in_addr;
  logic [7:0]  in_data;
  cmd_code_t   in_cmd;
  logic        in_rd_map;
  logic [WAVE_AW-1:0] in_rd_idx;
  logic        in_wr_wave;
  logic        in_wr_ctrl;
  logic        in_deform;
  logic        in_dup;
  logic [3:0]  reg_sel;
  logic [11:0] new_raw;
  logic [CH_W-1:0] per_ch;
  logic [CH_W-1:0] vol_ch;

  logic        div_start;
  logic [DIVN_W-1:0] div_n;
  logic [DIVD_W-1:0] div_d;
  logic        div_busy;
  logic [DIVN_W-1:0] div_q;
  logic [DIVD_W-1:0] div_r;
  logic [21:0] acc;
  logic [DIVN_W-1:0] sum_mag;

  logic signed [7:0]  wave_s;
  logic signed [12:0] prod;
  logic signed [DIVN_W:0]   val;
  logic signed [DIVN_W+3:0] scaled;
  logic [15:0] sample;

  assign in_addr    = s_tdata[7:0];
  assign in_data    = s_tdata[15:8];
  assign in_cmd     = cmd_code_t'(s_tuser);
  assign in_deform  = in_addr[7:5] == SEG_DEFORM;
  assign in_rd_map  = plus_mode ? (in_addr < ADDR_PLUS_WAVE_END)
                    : ((in_addr < ADDR_COMPAT_WAVE_END) || (in_addr[7:5] == SEG_COMPAT_WAVE4));
  assign in_rd_idx  = (!plus_mode && in_addr[7:5] == SEG_COMPAT_WAVE4)
                    ? {WAVE4_CH, in_addr[4:0]} : in_addr;
  assign lat_rd_idx = (!plus_mode && lat_addr[7:5] == SEG_COMPAT_WAVE4)
                    ? {WAVE4_CH, lat_addr[4:0]} : lat_addr;
  assign in_wr_wave = plus_mode ? (in_addr < ADDR_PLUS_WAVE_END)
                    : (in_addr < ADDR_COMPAT_WAVE_END);
  assign in_wr_ctrl = plus_mode ? (in_addr[7:5] == SEG_PLUS_CTRL)
                    : (in_addr[7:5] == SEG_COMPAT_CTRL);
  assign in_dup     = !plus_mode && (in_cmd == CMD_WRITE) && (in_addr[7] == 1'b0)
                    && (in_addr[6:5] == SEG_WAVE3);
  assign reg_sel    = in_addr[3:0];
  assign per_ch     = reg_sel[3:1];
  assign vol_ch     = CH_W'(reg_sel - 4'd10);
  assign new_raw    = reg_sel[0] ? {in_data[3:0], raw[per_ch][7:0]}
                                 : {raw[per_ch][11:8], in_data};

  assign ram_we    = (cmd.accept && in_cmd == CMD_WRITE && in_wr_wave) || cmd.dup_wr;
  assign ram_wdata = cmd.dup_wr ? lat_data : in_data;

  always_comb begin
    if (cmd.dup_wr) begin
      ram_addr = {WAVE4_CH, lat_addr[4:0]};
    end else if (cmd.mix_rd) begin
      ram_addr = {ch, pos[ch]};
    end else if (cmd.accept) begin
      ram_addr = (in_cmd == CMD_WRITE) ? in_addr : in_rd_idx;
    end else begin
      ram_addr = lat_rd_idx;
    end
  end

  wsc_ram #(
    .WIDTH(8),
    .DEPTH(WAVE_DEPTH)
  ) u_wave (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_q)
  );

  assign acc       = {4'd0, clk_rem} + {1'b0, chip_hz[25:5]};
  assign sum_mag   = sum[DIVN_W-1] ? DIVN_W'(-sum) : DIVN_W'(sum);
  assign div_start = cmd.div1_start || cmd.div2_start;
  assign div_n     = cmd.div1_start ? {{(DIVN_W-22){1'b0}}, acc} : sum_mag;
  assign div_d     = cmd.div1_start ? {{(DIVD_W-18){1'b0}}, rate_hz} : ticks;

  wsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .busy     (div_busy),
    .quotient (div_q),
    .remainder(div_r)
  );

  assign per    = {2'd0, act[ch]} + 14'd1;
  assign wave_s = wvalid_q ? $signed(ram_q) : -8'sd1;
  assign prod   = wave_s * $signed({1'b0, vol[ch]});

  always_comb begin
    if (ticks == '0) begin
      val = (DIVN_W+1)'(sum);
    end else if (sum[DIVN_W-1]) begin
      val = -$signed({1'b0, div_q});
    end else begin
      val = $signed({1'b0, div_q});
    end
    scaled = {val, 3'b000};
    if (scaled > (DIVN_W+4)'(32767)) begin
      sample = 16'h7fff;
    end else if (scaled < -(DIVN_W+4)'(32768)) begin
      sample = 16'h8000;
    end else begin
      sample = scaled[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plus_mode <= 1'b0;
      chip_hz   <= RST_CHIP_HZ;
      rate_hz   <= RST_RATE_HZ;
      enable    <= '0;
      deform    <= '0;
      clk_rem   <= '0;
      wvalid    <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        vol[i]   <= 4'd15;
        raw[i]   <= '0;
        act[i]   <= '0;
        phase[i] <= '0;
        pos[i]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index_t'(cfg_addr))
          CFG_PLUS_MODE: plus_mode <= cfg_data[0];
          CFG_CHIP_HZ:   chip_hz   <= cfg_data;
          CFG_RATE_HZ:   rate_hz   <= cfg_data[17:0];
          default: ;
        endcase
      end

      if (ram_we) begin
        wvalid[ram_addr] <= 1'b1;
      end

      if (cmd.accept) begin
        case (in_cmd)
          CMD_READ: begin
            if (in_deform) begin
              deform <= 8'hff;
            end
          end
          CMD_WRITE: begin
            if (in_wr_ctrl) begin
              if (reg_sel < 4'd10) begin
                raw[per_ch]   <= new_raw;
                act[per_ch]   <= narrow_period(new_raw, deform);
                phase[per_ch] <= '0;
                if (deform[5]) begin
                  pos[per_ch] <= '0;
                end
              end else if (reg_sel < 4'd15) begin
                vol[vol_ch] <= in_data[3:0];
              end else begin
                enable <= in_data[NUM_CH-1:0];
              end
            end else if (in_deform) begin
              deform <= in_data;
              for (int i = 0; i < NUM_CH; i++) begin
                act[i]   <= narrow_period(raw[i], in_data);
                phase[i] <= '0;
                if (in_data[5]) begin
                  pos[i] <= '0;
                end
              end
            end
          end
          CMD_SRESET: begin
            enable  <= '0;
            deform  <= '0;
            clk_rem <= '0;
            for (int i = 0; i < NUM_CH; i++) begin
              phase[i] <= '0;
              pos[i]   <= '0;
            end
          end
          default: ;
        endcase
      end

      if (cmd.div1_take) begin
        clk_rem <= div_r[17:0];
      end

      if (cmd.sub_step) begin
        if (cnt >= per) begin
          pos[ch] <= pos[ch] + 1'b1;
        end else begin
          phase[ch] <= cnt[12:0];
        end
      end

      if (cmd.load_read || cmd.load_sample) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wvalid_q <= (ram_addr < WAVE_AW'(WAVE_DEPTH)) && wvalid[ram_addr];
    if (cmd.accept) begin
      lat_addr  <= in_addr;
      lat_data  <= in_data;
      rd_mapped <= in_rd_map;
      ch        <= '0;
      tick_cnt  <= '0;
      ticks     <= '0;
      sum       <= '0;
    end
    if (cmd.div1_take) begin
      ticks <= div_q[DIVD_W-1:0];
    end
    if (cmd.ch_start) begin
      cnt <= {1'b0, phase[ch]} + 14'd32;
    end
    if (cmd.sub_step && cnt >= per) begin
      cnt <= cnt - per;
    end
    if (cmd.ch_next) begin
      ch <= (ch == CH_W'(NUM_CH - 1)) ? '0 : ch + 1'b1;
    end
    if (cmd.mix_acc && enable[ch]) begin
      sum <= sum + DIVN_W'(prod >>> 4);
    end
    if (cmd.tick_inc) begin
      tick_cnt <= tick_cnt + 1'b1;
    end
    if (cmd.load_read) begin
      out_kind   <= KIND_READ;
      out_rdata  <= (rd_mapped && wvalid_q) ? ram_q : 8'hff;
      out_sample <= '0;
    end
    if (cmd.load_sample) begin
      out_kind   <= KIND_SAMPLE;
      out_rdata  <= '0;
      out_sample <= sample;
    end
  end

  assign stat.kind         = in_cmd;
  assign stat.dup          = in_dup;
  assign stat.rate_zero    = rate_hz == '0;
  assign stat.div_busy     = div_busy;
  assign stat.q_zero       = div_q == '0;
  assign stat.short_period = act[ch] <= 12'd8;
  assign stat.cnt_ge       = cnt >= per;
  assign stat.last_ch      = ch == CH_W'(NUM_CH - 1);
  assign stat.ticks_zero   = ticks == '0;
  assign stat.last_tick    = DIVD_W'(tick_cnt + 1'b1) == ticks;
  assign stat.out_busy     = out_valid;

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_sample, out_rdata};
  assign m_tuser  = out_kind;

endmodule

>>> hdl/wsc_ctrl.sv
module wsc_ctrl import wsc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          case (stat.kind)
            CMD_READ:   state_next = S_RD;
            CMD_WRITE:  state_next = stat.dup ? S_DUP : S_IDLE;
            CMD_RENDER: begin
              if (stat.rate_zero) begin
                state_next = S_MRD;
              end else begin
                cmd.div1_start = 1'b1;
                state_next     = S_DIV1;
              end
            end
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_DUP: begin
        cmd.dup_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_RD: begin
        if (!stat.out_busy) begin
          cmd.load_read = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_DIV1: begin
        if (!stat.div_busy) begin
          cmd.div1_take = 1'b1;
          state_next    = stat.q_zero ? S_MRD : S_CH;
        end
      end
      S_CH: begin
        if (stat.short_period) begin
          cmd.ch_next = 1'b1;
          state_next  = stat.last_ch ? S_MRD : S_CH;
        end else begin
          cmd.ch_start = 1'b1;
          state_next   = S_SUB;
        end
      end
      S_SUB: begin
        cmd.sub_step = 1'b1;
        if (!stat.cnt_ge) begin
          cmd.ch_next = 1'b1;
          state_next  = stat.last_ch ? S_MRD : S_CH;
        end
      end
      S_MRD: begin
        cmd.mix_rd = 1'b1;
        state_next = S_MACC;
      end
      S_MACC: begin
        cmd.mix_acc = 1'b1;
        cmd.ch_next = 1'b1;
        if (!stat.last_ch) begin
          state_next = S_MRD;
        end else if (stat.ticks_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.tick_inc = 1'b1;
          state_next   = stat.last_tick ? S_AVG : S_CH;
        end
      end
      S_AVG: begin
        cmd.div2_start = 1'b1;
        state_next     = S_DIV2;
      end
      S_DIV2: begin
        if (!stat.div_busy) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.load_sample = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_read || cmd.load_sample) |-> !stat.out_busy)
    else $error("result loaded over an untaken beat");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.div1_start || cmd.div2_start) |-> !stat.div_busy)
    else $error("divider restarted while busy");

  a_sub_long: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUB) |-> !stat.short_period)
    else $error("phase step on a short period");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state != S_IDLE) || !$past(stat.kind == CMD_READ))
    else $error("read accepted without a result pass");

endmodule

>>> hdl/wavetable_sound_chip_unit.sv
// Five-channel wavetable sound chip with byte-wide registers.
// The slave channel carries one command beat: tuser holds the command
// (read, write, render, soft reset) and tdata the address and write byte.
// A read passes through the S_RD state and loads its result beat into the
// output register once an earlier result there has gone; no new command
// is taken before that. A write or a soft reset returns nothing, and a
// compatible-mode write to wave 3 also fills wave 4. A render runs the
// clock division, then for every channel tick one pass over the five
// channels and a mixing pass, and finally an averaging division; a zero
// output rate skips the clock division, and zero ticks give one mixing pass
// and no averaging. The divider is shared and the wave RAM has a single
// port. The configuration port writes the address map mode, the chip clock
// frequency and the output rate at indices 0, 1 and 2 and must only be used
// while idle. Reset sets every wave byte to 0xff at once through per-entry
// valid bits, volumes to 15, the chip clock and output rate to 3579545 Hz
// and 44100 Hz, and the map mode, periods, phases, positions, enables and
// deform to zero. A finished result waits in the output register while the
// master stalls; the next command is still taken, and its own result waits
// until that beat has gone.
module wavetable_sound_chip_unit import wsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // address, write_data
  input  logic [1:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // read_data, sample_out
  output logic [0:0]  m_tuser,   // result_kind
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [25:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  wsc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  wsc_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .cfg_we  (cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule

>>> tb/sv/wavetable_sound_chip_checker.sv
module wavetable_sound_chip_checker import wsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic [0:0]  m_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [25:0] cfg_data,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    result_kind_t kind;
    logic [7:0]   rd_byte;
    logic [15:0]  sample;
  } chip_result_t;

  chip_result_t result_q[$];

  logic [7:0]  wave_mem[WAVE_DEPTH];
  logic [3:0]  volume[NUM_CH];
  logic [11:0] raw_per[NUM_CH];
  logic [11:0] act_per[NUM_CH];
  logic [12:0] phase_cnt[NUM_CH];
  logic [4:0]  wave_pos[NUM_CH];
  logic [4:0]  enables;
  logic [7:0]  deform;
  logic [31:0] clk_rem;
  logic        plus_map;
  logic [25:0] chip_hz;
  logic [17:0] rate_hz;

  function automatic void soft_clear();
    enables = '0;
    deform = '0;
    clk_rem = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      phase_cnt[c] = '0;
      wave_pos[c] = '0;
    end
  endfunction

  function automatic void narrow(input int c);
    logic [11:0] p;
    p = raw_per[c];
    if (deform[1]) begin
      p = p & 12'h0ff;
    end else if (deform[0]) begin
      p = p >> 8;
    end
    act_per[c] = p;
    phase_cnt[c] = '0;
    if (deform[5]) begin
      wave_pos[c] = '0;
    end
  endfunction

  function automatic void store_wave(input int c, input logic [7:0] a, input logic [7:0] v);
    wave_mem[c * WAVE_LEN + a[4:0]] = v;
    if (!plus_map && c == 3) begin
      wave_mem[4 * WAVE_LEN + a[4:0]] = v;
    end
  endfunction

  function automatic void store_control(input logic [7:0] a, input logic [7:0] v);
    int r;
    r = a[3:0];
    if (r < 10) begin
      if (r % 2 == 1) begin
        raw_per[r / 2][11:8] = v[3:0];
      end else begin
        raw_per[r / 2][7:0] = v;
      end
      narrow(r / 2);
    end else if (r < 15) begin
      volume[r - 10] = v[3:0];
    end else begin
      enables = v[4:0];
    end
  endfunction

  function automatic void write_byte(input logic [7:0] a, input logic [7:0] v);
    if (plus_map) begin
      if (a < 8'ha0) begin
        store_wave(a >> 5, a, v);
      end else if (a < 8'hc0) begin
        store_control(a, v);
      end else if (a < 8'he0) begin
        deform = v;
        for (int c = 0; c < NUM_CH; c++) narrow(c);
      end
    end else begin
      if (a < 8'h80) begin
        store_wave(a >> 5, a, v);
      end else if (a < 8'ha0) begin
        store_control(a, v);
      end else if (a >= 8'hc0 && a < 8'he0) begin
        deform = v;
        for (int c = 0; c < NUM_CH; c++) narrow(c);
      end
    end
  endfunction

  function automatic logic [7:0] read_byte(input logic [7:0] a);
    logic [7:0] r;
    r = 8'hff;
    if (plus_map) begin
      if (a < 8'ha0) r = wave_mem[(a >> 5) * WAVE_LEN + a[4:0]];
    end else begin
      if (a < 8'h80) r = wave_mem[(a >> 5) * WAVE_LEN + a[4:0]];
      else if (a >= 8'ha0 && a < 8'hc0) r = wave_mem[4 * WAVE_LEN + a[4:0]];
    end
    if (a >= 8'hc0 && a < 8'he0) deform = 8'hff;
    return r;
  endfunction

  function automatic int mix_level();
    int m;
    int w;
    m = 0;
    for (int c = 0; c < NUM_CH; c++) begin
      if (enables[c]) begin
        w = $signed(wave_mem[c * WAVE_LEN + wave_pos[c]]);
        m += (w * int'(volume[c])) >>> 4;
      end
    end
    return m;
  endfunction

  function automatic void advance_channels();
    int unsigned per;
    int unsigned cnt;
    for (int c = 0; c < NUM_CH; c++) begin
      per = act_per[c] + 1;
      if (act_per[c] > 8) begin
        cnt = phase_cnt[c] + 32;
        while (cnt >= per) begin
          cnt -= per;
          wave_pos[c] = wave_pos[c] + 1;
        end
        phase_cnt[c] = cnt[12:0];
      end
    end
  endfunction

  function automatic logic [15:0] render_sample();
    longint sum;
    int unsigned ticks;
    int unsigned acc;
    sum = 0;
    ticks = 0;
    if (rate_hz != 0) begin
      acc = clk_rem + chip_hz / 32;
      ticks = acc / rate_hz;
      clk_rem = acc % rate_hz;
    end
    if (ticks == 0) begin
      sum = mix_level();
    end else begin
      for (int unsigned i = 0; i < ticks; i++) begin
        advance_channels();
        sum += mix_level();
      end
      sum = sum / longint'(ticks);
    end
    sum = sum * 8;
    if (sum > 32767) sum = 32767;
    else if (sum < -32768) sum = -32768;
    return sum[15:0];
  endfunction

  always @(posedge clk) begin
    chip_result_t r;
    chip_result_t got;
    if (rst) begin
      result_q.delete();
      errors = 0;
      for (int i = 0; i < WAVE_DEPTH; i++) wave_mem[i] = 8'hff;
      for (int c = 0; c < NUM_CH; c++) begin
        volume[c] = 4'hf;
        raw_per[c] = '0;
        act_per[c] = '0;
      end
      plus_map = 1'b0;
      chip_hz = RST_CHIP_HZ;
      rate_hz = RST_RATE_HZ;
      soft_clear();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_PLUS_MODE: plus_map = cfg_data[0];
          CFG_CHIP_HZ:   chip_hz = cfg_data;
          CFG_RATE_HZ:   rate_hz = cfg_data[17:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        case (cmd_code_t'(s_tuser))
          CMD_READ: begin
            r.kind = KIND_READ;
            r.rd_byte = read_byte(s_tdata[7:0]);
            r.sample = '0;
            result_q.push_back(r);
          end
          CMD_WRITE: write_byte(s_tdata[7:0], s_tdata[15:8]);
          CMD_RENDER: begin
            r.kind = KIND_SAMPLE;
            r.rd_byte = '0;
            r.sample = render_sample();
            result_q.push_back(r);
          end
          default: soft_clear();
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.kind = result_kind_t'(m_tuser[0]);
        got.rd_byte = m_tdata[7:0];
        got.sample = m_tdata[23:8];
        if (result_q.size() == 0) begin
          $display("%0t: unexpected beat kind=%0d read=%h sample=%h", $time,
                   got.kind, got.rd_byte, got.sample);
          errors++;
        end else begin
          r = result_q.pop_front();
          if (got.kind != r.kind || got.rd_byte != r.rd_byte || got.sample != r.sample) begin
            $display("%0t: expected kind=%0d read=%h sample=%h, got kind=%0d read=%h sample=%h",
                     $time, r.kind, r.rd_byte, r.sample, got.kind, got.rd_byte, got.sample);
            errors++;
          end
        end
      end
    end
    pending <= result_q.size();
  end

endmodule

>>> tb/sv/wavetable_sound_chip_unit_test.sv
module wavetable_sound_chip_unit_test import wsc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [25:0] cfg_data;
  int          errors;
  int          pending;

  int  send_idle;
  int  recv_stall;
  bit  cur_plus;
  bit  hold_go;
  bit  hold_on;

  wavetable_sound_chip_unit DUT (.*);

  wavetable_sound_chip_checker chk (.*);

  initial begin
    clk = 0;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = CMD_READ;
    m_tready = 0;
    cfg_we = 0;
    cfg_addr = CFG_PLUS_MODE;
    cfg_data = '0;
    send_idle = 0;
    recv_stall = 0;
    hold_go = 0;
    hold_on = 0;
  end

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    m_tready <= !hold_on && ($urandom_range(99) >= recv_stall);
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1;
    repeat (400) @(posedge clk);
    hold_on <= 0;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send(input cmd_code_t cmd, input logic [7:0] addr, input logic [7:0] data);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= cmd;
    s_tdata <= {data, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(input bit plus, input logic [25:0] hz, input logic [17:0] rate);
    drain();
    cur_plus = plus;
    cfg_we <= 1;
    cfg_addr <= CFG_PLUS_MODE;
    cfg_data <= 26'(plus);
    @(posedge clk);
    cfg_addr <= CFG_CHIP_HZ;
    cfg_data <= hz;
    @(posedge clk);
    cfg_addr <= CFG_RATE_HZ;
    cfg_data <= 26'(rate);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_item();
    int r;
    logic [7:0] ctrl;
    r = $urandom_range(99);
    ctrl = cur_plus ? 8'ha0 : 8'h80;
    if (r < 32) begin
      send(CMD_WRITE, 8'($urandom_range(cur_plus ? 159 : 127)), 8'($urandom_range(255)));
    end else if (r < 48) begin
      send(CMD_WRITE, ctrl | 8'($urandom_range(15)), 8'($urandom_range(255)));
    end else if (r < 52) begin
      send(CMD_WRITE, 8'hc0 | 8'($urandom_range(31)), 8'($urandom_range(255)));
    end else if (r < 67) begin
      send(CMD_READ, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end else if (r < 95) begin
      send(CMD_RENDER, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end else if (r < 97) begin
      send(CMD_SRESET, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end else begin
      send(CMD_WRITE, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    send_idle = idle;
    recv_stall = stall;
    for (int i = 0; i < count; i++) random_item();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    cur_plus = 0;

    send(CMD_READ, 8'h00, 8'h00);
    send(CMD_READ, 8'hff, 8'hff);
    send(CMD_WRITE, 8'h60, 8'h80);
    send(CMD_WRITE, 8'h7f, 8'h7f);
    send(CMD_READ, 8'ha0, 8'h00);
    send(CMD_READ, 8'h7f, 8'h00);
    send(CMD_WRITE, 8'ha5, 8'h12);
    send(CMD_WRITE, 8'he5, 8'h34);
    send(CMD_READ, 8'ha5, 8'h00);
    send(CMD_WRITE, 8'h80, 8'h10);
    send(CMD_WRITE, 8'h81, 8'hff);
    send(CMD_WRITE, 8'h86, 8'h05);
    send(CMD_WRITE, 8'h8a, 8'hff);
    send(CMD_WRITE, 8'h8e, 8'h00);
    send(CMD_WRITE, 8'h8f, 8'hff);
    send(CMD_RENDER, 8'h00, 8'h00);
    send(CMD_WRITE, 8'hc0, 8'h21);
    send(CMD_RENDER, 8'h00, 8'h00);
    send(CMD_WRITE, 8'hdf, 8'h02);
    send(CMD_RENDER, 8'h00, 8'h00);
    send(CMD_READ, 8'hc7, 8'h00);
    send(CMD_RENDER, 8'h00, 8'h00);
    send(CMD_SRESET, 8'h00, 8'h00);
    send(CMD_RENDER, 8'h00, 8'h00);

    configure(0, 26'd3579545, 18'd44100);
    run_phase(0, 0, 30);
    hold_go <= 1;
    for (int i = 0; i < 20; i++) send(CMD_READ, 8'($urandom_range(255)), 8'h00);
    drain();
    run_phase(0, 0, 20);

    configure(1, 26'd67108863, 18'd192000);
    send(CMD_WRITE, 8'h9f, 8'hff);
    send(CMD_READ, 8'h9f, 8'h00);
    send(CMD_READ, 8'ha0, 8'h00);
    run_phase(71, 0, 62);

    configure(0, 26'd32, 18'd8000);
    run_phase(0, 71, 65);

    configure(1, 26'd1000000, 18'd0);
    run_phase(21, 21, 65);

    configure(0, 26'd67108863, 18'd8000);
    send_idle = 0;
    recv_stall = 0;
    send(CMD_WRITE, 8'h8f, 8'h1f);
    send(CMD_RENDER, 8'h00, 8'h00);
    send(CMD_RENDER, 8'h00, 8'h00);
    send(CMD_RENDER, 8'h00, 8'h00);

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
